@@ rtl/core/cle_pkg.sv @@
// Shared constants and types for the console line editor.
package cle_pkg;

	localparam int LINE_DEPTH = 16;
	localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// characters
	localparam logic [6:0] CH_BELL   = 7'h07;
	localparam logic [6:0] CH_BS     = 7'h08;
	localparam logic [6:0] CH_LF     = 7'h0A;
	localparam logic [6:0] CH_CR     = 7'h0D;
	localparam logic [6:0] CH_RETYPE = 7'h12;
	localparam logic [6:0] CH_KILL   = 7'h15;
	localparam logic [6:0] CH_SPACE  = 7'h20;
	localparam logic [6:0] CH_HASH   = 7'h23;
	localparam logic [6:0] CH_AT     = 7'h40;
	localparam logic [6:0] CH_R      = 7'h52;
	localparam logic [6:0] CH_CARET  = 7'h5E;
	localparam logic [6:0] CH_DEL    = 7'h7F;

	// result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// decoded operations
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_NL     = 3'd1;
	localparam logic [2:0] OP_RUBOUT = 3'd2;
	localparam logic [2:0] OP_KILL   = 3'd3;
	localparam logic [2:0] OP_RETYPE = 3'd4;
	localparam logic [2:0] OP_BELL   = 3'd5;
	localparam logic [2:0] OP_STORE  = 3'd6;

	typedef struct packed {
		logic [2:0] op;
		logic [6:0] ch;
	} cmd_t;

endpackage

@@ rtl/core/cle_classify.sv @@
// Character decoder: masks, maps CR to LF and picks the edit operation.
module cle_classify (
	input  logic [7:0]                 rx_byte,
	input  logic [cle_pkg::FILL_W-1:0] fill,
	output cle_pkg::cmd_t              cmd
);

	logic [6:0] c;

	always_comb begin
		c = rx_byte[6:0];
		if (c == cle_pkg::CH_CR) begin
			c = cle_pkg::CH_LF;
		end
		cmd.ch = c;
		unique case (c) inside
			cle_pkg::CH_LF: begin
				cmd.op = cle_pkg::OP_NL;
			end
			cle_pkg::CH_DEL, cle_pkg::CH_BS, cle_pkg::CH_HASH: begin
				cmd.op = (fill == '0) ? cle_pkg::OP_BELL : cle_pkg::OP_RUBOUT;
			end
			cle_pkg::CH_KILL, cle_pkg::CH_AT: begin
				cmd.op = (fill == '0) ? cle_pkg::OP_NONE : cle_pkg::OP_KILL;
			end
			cle_pkg::CH_RETYPE: begin
				cmd.op = cle_pkg::OP_RETYPE;
			end
			default: begin
				if (c < cle_pkg::CH_SPACE || c == cle_pkg::CH_DEL) begin
					cmd.op = cle_pkg::OP_BELL;
				end else if (fill >= cle_pkg::FILL_W'(cle_pkg::LINE_DEPTH)) begin
					cmd.op = cle_pkg::OP_BELL;  // line full, drop
				end else begin
					cmd.op = cle_pkg::OP_STORE;
				end
			end
		endcase
	end

endmodule

@@ rtl/core/console_line_editor_unit.sv @@
// Console line editor top level: sequencer, line store and result register.
//
// Input channel: rx_byte with in_valid/in_ready; one received character per
// transfer. Output channel: kind/value/last with out_valid/out_ready; each
// transfer is one echo byte, delivered line byte or line end marker, and last
// marks the final result of a character.
// A character is decoded in its accept cycle; a small sequencer then walks a
// fixed echo prefix and the stored line through one shared index counter and
// compare, producing one result per cycle into the output register while the
// receiver does not stall. Results per character: none for a kill on an empty
// line, 1 for store/bell, 3 for erase, 3*n for kill, 5+n for retype, 4+n for
// newline (n = stored characters, at most 16). The accept registers the
// command into the sequencer state, from which the first result enters the
// output register. in_ready is high only while the sequencer is idle; the
// next character is taken while the final result still waits in the output
// register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset clears the fill count, the sequencer and the output valid; the line
// store contents are not cleared and only written entries are ever read.
module console_line_editor_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [6:0] value,
	output logic       last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRE  = 2'd1;
	localparam logic [1:0] ST_LOOP = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	localparam int FW = cle_pkg::FILL_W;
	localparam int IW = cle_pkg::IDX_W;

	logic [1:0]    state_q, state_d;
	logic [2:0]    op_q;
	logic [6:0]    ch_q;
	logic [2:0]    step_q, step_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [1:0]    sub_q, sub_d;
	logic [FW-1:0] len_q;
	logic [FW-1:0] fill_q;
	logic [6:0]    store_q [cle_pkg::LINE_DEPTH];

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [6:0]    value_q;
	logic          last_q;

	cle_pkg::cmd_t cmd;
	logic          in_fire;
	logic          emit;
	logic [1:0]    e_kind;
	logic [6:0]    e_value;
	logic          e_last;
	logic [2:0]    pre_len;
	logic [2:0]    nl_step;
	logic          pre_end;
	logic          idx_last;
	logic [6:0]    store_rd;

	cle_classify u_classify (
		.rx_byte (rx_byte),
		.fill    (fill_q),
		.cmd     (cmd)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign emit     = (state_q != ST_IDLE) && (!out_valid_q || out_ready);

	assign store_rd = store_q[idx_q];
	assign idx_last = (FW'(idx_q) == len_q - FW'(1));

	always_comb begin
		case (op_q)
			cle_pkg::OP_NL:     pre_len = 3'd3;
			cle_pkg::OP_RETYPE: pre_len = 3'd5;
			cle_pkg::OP_RUBOUT: pre_len = 3'd3;
			default:            pre_len = 3'd1;
		endcase
		pre_end = (step_q == pre_len - 3'd1);
		// position inside the LF CR DEL newline echo
		nl_step = (op_q == cle_pkg::OP_RETYPE) ? step_q - 3'd2 : step_q;
	end

	always_comb begin
		e_kind  = cle_pkg::KIND_ECHO;
		e_value = cle_pkg::CH_BELL;
		e_last  = 1'b0;
		state_d = state_q;
		step_d  = step_q;
		idx_d   = idx_q;
		sub_d   = sub_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_PRE: begin
				case (op_q)
					cle_pkg::OP_NL, cle_pkg::OP_RETYPE: begin
						if (op_q == cle_pkg::OP_RETYPE && step_q == 3'd0) begin
							e_value = cle_pkg::CH_CARET;
						end else if (op_q == cle_pkg::OP_RETYPE && step_q == 3'd1) begin
							e_value = cle_pkg::CH_R;
						end else if (nl_step == 3'd0) begin
							e_value = cle_pkg::CH_LF;
						end else if (nl_step == 3'd1) begin
							e_value = cle_pkg::CH_CR;
						end else begin
							e_value = cle_pkg::CH_DEL;
						end
					end
					cle_pkg::OP_RUBOUT: begin
						e_value = (step_q == 3'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
					end
					cle_pkg::OP_STORE: begin
						e_value = ch_q;
					end
					default: begin
						e_value = cle_pkg::CH_BELL;
					end
				endcase
				if (pre_end) begin
					idx_d = '0;
					sub_d = '0;
					if (op_q == cle_pkg::OP_NL) begin
						state_d = (len_q != '0) ? ST_LOOP : ST_END;
					end else if (op_q == cle_pkg::OP_RETYPE && len_q != '0) begin
						state_d = ST_LOOP;
					end else begin
						state_d = ST_IDLE;
						e_last  = 1'b1;
					end
				end else begin
					step_d = step_q + 3'd1;
				end
			end
			ST_LOOP: begin
				case (op_q)
					cle_pkg::OP_NL: begin
						e_kind  = cle_pkg::KIND_LINE;
						e_value = store_rd;
						if (idx_last) begin
							state_d = ST_END;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
					cle_pkg::OP_RETYPE: begin
						e_value = store_rd;
						if (idx_last) begin
							state_d = ST_IDLE;
							e_last  = 1'b1;
						end else begin
							idx_d = idx_q + IW'(1);
						end
					end
					cle_pkg::OP_KILL: begin
						// BS SP BS per stored character
						e_value = (sub_q == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
						if (sub_q == 2'd2) begin
							sub_d = 2'd0;
							if (idx_last) begin
								state_d = ST_IDLE;
								e_last  = 1'b1;
							end else begin
								idx_d = idx_q + IW'(1);
							end
						end else begin
							sub_d = sub_q + 2'd1;
						end
					end
					default: begin
						state_d = ST_IDLE;
						e_last  = 1'b1;
					end
				endcase
			end
			ST_END: begin
				e_kind  = cle_pkg::KIND_END;
				e_value = '0;
				e_last  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= cle_pkg::OP_NONE;
			ch_q    <= '0;
			step_q  <= '0;
			idx_q   <= '0;
			sub_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
		end else if (in_fire) begin
			op_q   <= cmd.op;
			ch_q   <= cmd.ch;
			step_q <= '0;
			idx_q  <= '0;
			sub_q  <= '0;
			len_q  <= fill_q;
			case (cmd.op)
				cle_pkg::OP_NONE: state_q <= ST_IDLE;
				cle_pkg::OP_KILL: state_q <= ST_LOOP;
				default:          state_q <= ST_PRE;
			endcase
			case (cmd.op)
				cle_pkg::OP_NL, cle_pkg::OP_KILL: fill_q <= '0;
				cle_pkg::OP_RUBOUT:               fill_q <= fill_q - FW'(1);
				cle_pkg::OP_STORE:                fill_q <= fill_q + FW'(1);
				default:                          fill_q <= fill_q;
			endcase
		end else if (emit) begin
			state_q <= state_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			sub_q   <= sub_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && cmd.op == cle_pkg::OP_STORE) begin
			store_q[fill_q[IW-1:0]] <= cmd.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= e_kind;
			value_q <= e_value;
			last_q  <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(cle_pkg::LINE_DEPTH))
		else $error("fill count beyond line depth");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == cle_pkg::KIND_END |-> last_q && value_q == '0)
		else $error("end marker not final or not zero");

	a_done_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_d == ST_IDLE |-> e_last)
		else $error("sequencer finished without last");

	a_loop_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOP |-> FW'(idx_q) < len_q)
		else $error("line index past stored length");

endmodule

@@ verif/tb_console_line_editor_unit.sv @@
// Self-checking testbench for the console line editor: directed and random typing, checked per result.
`timescale 1ns / 100ps

module tb_console_line_editor_unit;

	typedef struct {
		logic [1:0] kind;
		logic [6:0] value;
		logic       last;
	} editor_result_t;

	// Mirrors the editor's line store and holds the results each character still owes.
	class line_editor_shadow;
		logic [6:0]     shadow_line [cle_pkg::LINE_DEPTH];
		int             shadow_fill;
		editor_result_t due_results [$];
		int             mismatches;
		int             results_matched;
		int             lines_delivered;
		int             full_bells;

		function new();
			shadow_fill = 0;
			mismatches = 0;
			results_matched = 0;
			lines_delivered = 0;
			full_bells = 0;
		endfunction

		function void owe(logic [1:0] k, logic [6:0] v);
			editor_result_t r;
			r.kind = k;
			r.value = v;
			r.last = 1'b0;
			due_results.push_back(r);
		endfunction

		function void owe_rubout();
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE);
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
		endfunction

		function void owe_newline();
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_LF);
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_CR);
			owe(cle_pkg::KIND_ECHO, cle_pkg::CH_DEL);
		endfunction

		// Work out everything one transferred character should produce.
		function void take_char(logic [7:0] rx);
			logic [6:0]     c;
			int             due_at_start;
			editor_result_t r;
			due_at_start = due_results.size();
			c = rx[6:0];
			if (c == cle_pkg::CH_CR)
				c = cle_pkg::CH_LF;
			if (c == cle_pkg::CH_LF) begin
				owe_newline();
				for (int i = 0; i < shadow_fill; i++)
					owe(cle_pkg::KIND_LINE, shadow_line[i]);
				owe(cle_pkg::KIND_END, 7'd0);
				shadow_fill = 0;
			end else if (c == cle_pkg::CH_DEL || c == cle_pkg::CH_BS || c == cle_pkg::CH_HASH) begin
				if (shadow_fill == 0) begin
					owe(cle_pkg::KIND_ECHO, cle_pkg::CH_BELL);
				end else begin
					shadow_fill--;
					owe_rubout();
				end
			end else if (c == cle_pkg::CH_KILL || c == cle_pkg::CH_AT) begin
				while (shadow_fill > 0) begin
					shadow_fill--;
					owe_rubout();
				end
			end else if (c == cle_pkg::CH_RETYPE) begin
				owe(cle_pkg::KIND_ECHO, cle_pkg::CH_CARET);
				owe(cle_pkg::KIND_ECHO, cle_pkg::CH_R);
				owe_newline();
				for (int i = 0; i < shadow_fill; i++)
					owe(cle_pkg::KIND_ECHO, shadow_line[i]);
			end else if (c < cle_pkg::CH_SPACE || c == cle_pkg::CH_DEL) begin
				owe(cle_pkg::KIND_ECHO, cle_pkg::CH_BELL);
			end else if (shadow_fill >= cle_pkg::LINE_DEPTH) begin
				full_bells++;
				owe(cle_pkg::KIND_ECHO, cle_pkg::CH_BELL);
			end else begin
				shadow_line[shadow_fill] = c;
				shadow_fill++;
				owe(cle_pkg::KIND_ECHO, c);
			end
			if (due_results.size() > due_at_start) begin
				r = due_results.pop_back();
				r.last = 1'b1;
				due_results.push_back(r);
			end
		endfunction

		task log_mismatch(string what, int got, int want);
			mismatches++;
			$display("%0t ns  MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		endtask

		task match_result(logic [1:0] k, logic [6:0] v, logic l);
			editor_result_t e;
			if (due_results.size() == 0) begin
				log_mismatch("result with nothing outstanding, value", int'(v), 0);
			end else begin
				e = due_results.pop_front();
				if (k !== e.kind)
					log_mismatch("kind", int'(k), int'(e.kind));
				if (v !== e.value)
					log_mismatch("value", int'(v), int'(e.value));
				if (l !== e.last)
					log_mismatch("last", int'(l), int'(e.last));
				if (k === cle_pkg::KIND_END)
					lines_delivered++;
				results_matched++;
			end
		endtask
	endclass

	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 60;
	localparam int PHASE_CHARS  = 30;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [6:0] value;
	logic       last;

	line_editor_shadow shadow;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_toggle = 1'b0;
	bit  hold_seen = 1'b0;
	int  hold_left = 0;
	int  chars_sent = 0;

	console_line_editor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.value    (value),
		.last     (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_console_line_editor_unit: errors");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off counted here when requested.
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.match_result(kind, value, last);
	end

	// Offer one character; valid stays up across back-to-back transfers.
	task automatic send_char(input logic [7:0] b);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shadow.take_char(b);
		chars_sent++;
	endtask

	function automatic logic [7:0] random_printable();
		logic [7:0] b;
		b[7] = 1'($urandom_range(0, 1));
		b[6:0] = 7'($urandom_range(32, 126));
		return b;
	endfunction

	function automatic logic [7:0] random_edit();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = {1'b0, cle_pkg::CH_DEL};
			1: b = {1'b0, cle_pkg::CH_BS};
			2: b = {1'b0, cle_pkg::CH_HASH};
			3: b = {1'b0, cle_pkg::CH_KILL};
			4: b = {1'b0, cle_pkg::CH_AT};
			5: b = {1'b0, cle_pkg::CH_RETYPE};
			6: b = 8'($urandom_range(0, 31));
			default: b = 8'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 3) == 0)
			b[7] = 1'b1;
		return b;
	endfunction

	// A typed line: mostly printable text with the odd edit, then usually CR or LF.
	// Lengths past the store depth exercise the full-line bell.
	task automatic type_random_line();
		int len;
		len = $urandom_range(0, 20);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 15)
				send_char(random_edit());
			else
				send_char(random_printable());
		end
		if ($urandom_range(99) < 10)
			send_char(8'($urandom_range(0, 255)));
		else
			send_char({1'($urandom_range(0, 1)),
				($urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF)});
	endtask

	task automatic random_phase(int idle_pct, int stall);
		int target;
		target = chars_sent + PHASE_CHARS;
		send_idle_pct = idle_pct;
		stall_pct <= stall;
		while (chars_sent < target)
			type_random_line();
	endtask

	initial begin
		logic [7:0] directed [$];
		shadow = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-line edits, kill with nothing stored, bare newline, store
		// extremes, masked high bit, retype, erases, kills with content, CR
		directed = '{8'h23, 8'h15, 8'h40, 8'h0A, 8'h20, 8'h7E, 8'hC1, 8'h00,
			8'h12, 8'h7F, 8'h08, 8'h92, 8'h61, 8'h62, 8'h40, 8'h63, 8'h95,
			8'h64, 8'h0D, 8'hFF, 8'h1F, 8'h07, 8'h8D, 8'h88};
		foreach (directed[i])
			send_char(directed[i]);

		random_phase(0, 0);
		random_phase(70, 0);
		hold_toggle <= ~hold_toggle;
		random_phase(0, 70);
		random_phase(7, 7);
		in_valid <= 1'b0;

		while (shadow.due_results.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Typed %0d characters; %0d results checked, %0d lines delivered,",
			chars_sent, shadow.results_matched, shadow.lines_delivered);
		$display("%0d characters refused on a full line, %0d mismatches.",
			shadow.full_bells, shadow.mismatches);
		if (shadow.mismatches == 0)
			$display("tb_console_line_editor_unit: clean");
		else
			$display("tb_console_line_editor_unit: errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/cle_pkg.sv
rtl/core/cle_classify.sv
rtl/core/console_line_editor_unit.sv
verif/tb_console_line_editor_unit.sv
